>>> sv/ose_pkg.sv
package ose_pkg;

    localparam int OPCODE_W = 4;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ         = 4'd0,
        OP_PUSH         = 4'd1,
        OP_PUSH_UNDER   = 4'd2,
        OP_DUP          = 4'd3,
        OP_DUP_SECOND   = 4'd4,
        OP_SWAP         = 4'd5,
        OP_ROT          = 4'd6,
        OP_POP          = 4'd7,
        OP_POP_N        = 4'd8,
        OP_DROP_SECOND  = 4'd9,
        OP_DROP_N_UNDER = 4'd10
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_READ3,
        S_WRITE,
        S_COMMIT,
        S_FETCH,
        S_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       rd_pair;
        logic       rd_third;
        logic       cap_pair;
        logic       cap_third;
        logic       wr_en;
        logic [1:0] wr_step;
        logic       commit;
        logic       load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic       err;
        logic       third;
        logic [1:0] n_wr;
    } t_dp_stat;

endpackage

>>> sv/ose_intf.sv
interface ose_in_if import ose_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, opcode, value, count, input ready);
    modport sink (input valid, opcode, value, count, output ready);
endinterface

interface ose_out_if import ose_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  top_value;
    logic [VALUE_W-1:0]  second_value;
    logic [DEPTH_W-1:0]  depth_now;
    logic [STATUS_W-1:0] status;

    modport source (output valid, top_value, second_value, depth_now, status, input ready);
    modport sink (input valid, top_value, second_value, depth_now, status, output ready);
endinterface

>>> sv/operand_stack_engine.sv
// operand stack of object handles: one operation word in, one result word out (top, second,
// depth, status). the entries live in a memory with one write port and two registered read
// ports, so an operation is a short sequence: read the top pair, read the third entry for
// rot, write each moved or new entry one per cycle, update the depth, re-read the new top
// pair and load the result register. an operation that fails with underflow or overflow
// leaves the stack untouched and goes from the first read straight to loading the result;
// read, pop, pop_n and other depth-only changes skip the write steps. the input side is
// ready again while a finished result waits in the output register. stack entries are not
// cleared at reset and need no clearing pass: only entries below the current depth are
// ever reported.
module operand_stack_engine import ose_pkg::*; #(
    parameter int STACK_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ose_in_if.sink    i_in,
    ose_out_if.source o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ose_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ose_datapath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_opcode       (i_in.opcode),
        .i_value        (i_in.value),
        .i_count        (i_in.count),
        .o_top_value    (o_out.top_value),
        .o_second_value (o_out.second_value),
        .o_depth_now    (o_out.depth_now),
        .o_status       (o_out.status)
    );

endmodule

>>> sv/ose_datapath.sv
module ose_datapath import ose_pkg::*; #(
    parameter int STACK_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [COUNT_W-1:0]  i_count,
    output logic [VALUE_W-1:0]  o_top_value,
    output logic [VALUE_W-1:0]  o_second_value,
    output logic [DEPTH_W-1:0]  o_depth_now,
    output logic [STATUS_W-1:0] o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int NW = ((DW > COUNT_W) ? DW : COUNT_W) + 1;
    localparam int HW = HANDLE_WIDTH;

    logic [HW-1:0] mem [STACK_DEPTH];

    t_opcode            r_op;
    logic [HW-1:0]      r_val;
    logic [COUNT_W-1:0] r_cnt;
    logic [DW-1:0]      r_depth;
    logic [DW-1:0]      n_depth;
    logic [HW-1:0]      r_t0;
    logic [HW-1:0]      r_t1;
    logic [HW-1:0]      r_t2;
    logic [HW-1:0]      r_rd0;
    logic [HW-1:0]      r_rd1;
    t_status            r_status;
    logic [VALUE_W-1:0] r_top;
    logic [VALUE_W-1:0] r_second;
    logic [DEPTH_W-1:0] r_depth_out;
    t_status            r_status_out;

    logic [NW-1:0] need;
    logic          grow;
    logic          room;
    logic          third;
    logic [1:0]    n_wr;
    t_status       status_now;

    logic [DW-1:0] d_m1;
    logic [DW-1:0] d_m2;
    logic [DW-1:0] d_m3;
    logic [DW-1:0] d_mn;
    logic [DW-1:0] rd_addr;
    logic [DW-1:0] wr_addr;
    logic [HW-1:0] wr_data;

    assign d_m1 = r_depth - DW'(1);
    assign d_m2 = r_depth - DW'(2);
    assign d_m3 = r_depth - DW'(3);
    // count is below depth whenever this address is used
    assign d_mn = d_m1 - DW'(r_cnt);

    // entry demand and growth per operation
    always_comb begin
        need  = '0;
        grow  = 1'b0;
        third = 1'b0;
        n_wr  = 2'd0;
        case (r_op)
            OP_PUSH: begin
                grow = 1'b1;
                n_wr = 2'd1;
            end
            OP_PUSH_UNDER: begin
                need = NW'(1);
                grow = 1'b1;
                n_wr = 2'd2;
            end
            OP_DUP: begin
                need = NW'(1);
                grow = 1'b1;
                n_wr = 2'd1;
            end
            OP_DUP_SECOND: begin
                need = NW'(2);
                grow = 1'b1;
                n_wr = 2'd1;
            end
            OP_SWAP: begin
                need = NW'(2);
                n_wr = 2'd2;
            end
            OP_ROT: begin
                need  = NW'(3);
                third = 1'b1;
                n_wr  = 2'd3;
            end
            OP_POP: begin
                need = NW'(1);
            end
            OP_POP_N: begin
                need = NW'(r_cnt);
            end
            OP_DROP_SECOND: begin
                need = NW'(2);
                n_wr = 2'd1;
            end
            OP_DROP_N_UNDER: begin
                need = NW'(r_cnt) + NW'(1);
                n_wr = 2'd1;
            end
            default: begin
                need = '0;
            end
        endcase
        room = (r_depth != DW'(STACK_DEPTH));
        if (NW'(r_depth) < need) begin
            status_now = ST_UNDER;
        end else if (grow && !room) begin
            status_now = ST_OVER;
        end else begin
            status_now = ST_OK;
        end
    end

    assign o_stat.err   = (status_now != ST_OK);
    assign o_stat.third = third;
    assign o_stat.n_wr  = n_wr;

    // one entry written per step
    always_comb begin
        wr_addr = r_depth;
        wr_data = r_t0;
        case (r_op)
            OP_PUSH: begin
                wr_data = r_val;
            end
            OP_PUSH_UNDER: begin
                if (i_cmd.wr_step != 2'd0) begin
                    wr_addr = d_m1;
                    wr_data = r_val;
                end
            end
            OP_DUP_SECOND: begin
                wr_data = r_t1;
            end
            OP_SWAP: begin
                if (i_cmd.wr_step == 2'd0) begin
                    wr_addr = d_m1;
                    wr_data = r_t1;
                end else begin
                    wr_addr = d_m2;
                    wr_data = r_t0;
                end
            end
            OP_ROT: begin
                if (i_cmd.wr_step == 2'd0) begin
                    wr_addr = d_m1;
                    wr_data = r_t2;
                end else if (i_cmd.wr_step == 2'd1) begin
                    wr_addr = d_m2;
                    wr_data = r_t0;
                end else begin
                    wr_addr = d_m3;
                    wr_data = r_t1;
                end
            end
            OP_DROP_SECOND: begin
                wr_addr = d_m2;
            end
            OP_DROP_N_UNDER: begin
                wr_addr = d_mn;
            end
            default: begin
                wr_addr = r_depth;
            end
        endcase
    end

    always_comb begin
        case (r_op)
            OP_PUSH, OP_PUSH_UNDER, OP_DUP, OP_DUP_SECOND: n_depth = r_depth + DW'(1);
            OP_POP, OP_DROP_SECOND:                        n_depth = d_m1;
            OP_POP_N, OP_DROP_N_UNDER:                     n_depth = r_depth - DW'(r_cnt);
            default:                                       n_depth = r_depth;
        endcase
    end

    assign rd_addr = i_cmd.rd_third ? d_m3 : d_m1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_pair || i_cmd.rd_third) begin
            r_rd0 <= mem[rd_addr[AW-1:0]];
            r_rd1 <= mem[d_m2[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.commit) begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= t_opcode'(i_opcode);
            r_val <= HW'(i_value);
            r_cnt <= i_count;
        end
        if (i_cmd.cap_pair) begin
            r_t0     <= r_rd0;
            r_t1     <= r_rd1;
            r_status <= status_now;
        end
        if (i_cmd.cap_third) begin
            r_t2 <= r_rd0;
        end
        if (i_cmd.load) begin
            r_top        <= (r_depth != '0) ? VALUE_W'(r_rd0) : '0;
            r_second     <= (r_depth > DW'(1)) ? VALUE_W'(r_rd1) : '0;
            r_depth_out  <= DEPTH_W'(r_depth);
            r_status_out <= r_status;
        end
    end

    assign o_top_value    = r_top;
    assign o_second_value = r_second;
    assign o_depth_now    = r_depth_out;
    assign o_status       = r_status_out;

endmodule

>>> sv/ose_ctrl.sv
module ose_ctrl import ose_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_step;
    logic [1:0] n_step;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_step = 2'd0;
                if (i_stat.err) begin
                    // stack untouched, top pair already read
                    n_state = S_LOAD;
                end else if (i_stat.third) begin
                    n_state = S_READ3;
                end else if (i_stat.n_wr != 2'd0) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_READ3: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (r_step == i_stat.n_wr - 2'd1) begin
                    n_state = S_COMMIT;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_COMMIT: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept  = i_in_valid;
                o_cmd.rd_pair = i_in_valid;
            end
            S_READ: begin
                o_cmd.cap_pair = 1'b1;
                o_cmd.rd_third = i_stat.third && !i_stat.err;
            end
            S_READ3: begin
                o_cmd.cap_third = 1'b1;
            end
            S_WRITE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_step = r_step;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            S_FETCH: begin
                o_cmd.rd_pair = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase

        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/ose_checker.sv
module ose_checker import ose_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [VALUE_W-1:0]  i_top_value,
    input logic [VALUE_W-1:0]  i_second_value,
    input logic [DEPTH_W-1:0]  i_depth_now,
    input logic [STATUS_W-1:0] i_status
);

    logic [DEPTH_W-1:0] r_last_depth;

    // depth of the last word taken at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_depth <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_depth <= i_depth_now;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the operation finished");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_top_value)
            && $stable(i_second_value) && $stable(i_depth_now) && $stable(i_status))
        else $error("stalled result word changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_depth_now == '0 |-> i_top_value == '0 && i_second_value == '0)
        else $error("empty stack reports entries");

    a_single_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_depth_now == DEPTH_W'(1) |-> i_second_value == '0)
        else $error("second entry reported with one entry held");

    a_error_keeps_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_UNDER || i_status == ST_OVER)
            |-> i_depth_now == r_last_depth)
        else $error("failed operation changed the depth");

endmodule

bind operand_stack_engine ose_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_top_value    (o_out.top_value),
    .i_second_value (o_out.second_value),
    .i_depth_now    (o_out.depth_now),
    .i_status       (o_out.status)
);

>>> test/ose_check.sv
`timescale 1ns / 100ps

module ose_check import ose_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ose_in_if    i_op_mon,
    ose_out_if   i_res_mon,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        logic [VALUE_W-1:0]  top_value;
        logic [VALUE_W-1:0]  second_value;
        logic [DEPTH_W-1:0]  depth_now;
        logic [STATUS_W-1:0] status;
    } t_stack_view;

    localparam int PRINT_CAP = 100;

    logic [VALUE_W-1:0] handle_mem [STACK_DEPTH];
    int                 handle_cnt;
    t_stack_view        view_queue [$];
    t_stack_view        want_view;
    int                 mismatch_total;

    initial begin
        handle_cnt     = 0;
        mismatch_total = 0;
        o_pending      = 0;
        o_fail_count   = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_total < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // applies one operation word to the stack copy and returns the view that follows
    function automatic t_stack_view apply_stack_op(input logic [OPCODE_W-1:0] op,
                                                   input logic [VALUE_W-1:0]  v,
                                                   input logic [COUNT_W-1:0]  n);
        int                 need;
        bit                 grow;
        int                 top_ix;
        logic [VALUE_W-1:0] held;
        t_stack_view        view;
        need        = 0;
        grow        = 1'b0;
        view.status = ST_OK;
        case (op)
            OP_PUSH:         grow = 1'b1;
            OP_PUSH_UNDER: begin
                need = 1;
                grow = 1'b1;
            end
            OP_DUP: begin
                need = 1;
                grow = 1'b1;
            end
            OP_DUP_SECOND: begin
                need = 2;
                grow = 1'b1;
            end
            OP_SWAP:         need = 2;
            OP_ROT:          need = 3;
            OP_POP:          need = 1;
            OP_POP_N:        need = int'(n);
            OP_DROP_SECOND:  need = 2;
            OP_DROP_N_UNDER: need = int'(n) + 1;
            default:         need = 0;
        endcase

        // the entry count is checked ahead of the room left
        top_ix = handle_cnt - 1;
        if (handle_cnt < need) begin
            view.status = ST_UNDER;
        end else if (grow && handle_cnt >= STACK_DEPTH) begin
            view.status = ST_OVER;
        end else begin
            case (op)
                OP_PUSH: begin
                    handle_mem[handle_cnt] = v;
                    handle_cnt++;
                end
                OP_PUSH_UNDER: begin
                    handle_mem[handle_cnt] = handle_mem[top_ix];
                    handle_mem[top_ix]     = v;
                    handle_cnt++;
                end
                OP_DUP: begin
                    handle_mem[handle_cnt] = handle_mem[top_ix];
                    handle_cnt++;
                end
                OP_DUP_SECOND: begin
                    handle_mem[handle_cnt] = handle_mem[top_ix-1];
                    handle_cnt++;
                end
                OP_SWAP: begin
                    held                 = handle_mem[top_ix];
                    handle_mem[top_ix]   = handle_mem[top_ix-1];
                    handle_mem[top_ix-1] = held;
                end
                OP_ROT: begin
                    // third entry comes up to the top, the top two sink by one
                    held                 = handle_mem[top_ix];
                    handle_mem[top_ix]   = handle_mem[top_ix-2];
                    handle_mem[top_ix-2] = handle_mem[top_ix-1];
                    handle_mem[top_ix-1] = held;
                end
                OP_POP:          handle_cnt--;
                OP_POP_N:        handle_cnt -= int'(n);
                OP_DROP_SECOND: begin
                    handle_mem[top_ix-1] = handle_mem[top_ix];
                    handle_cnt--;
                end
                OP_DROP_N_UNDER: begin
                    handle_mem[top_ix-int'(n)] = handle_mem[top_ix];
                    handle_cnt -= int'(n);
                end
                default: ;
            endcase
        end

        view.top_value    = (handle_cnt >= 1) ? handle_mem[handle_cnt-1] : '0;
        view.second_value = (handle_cnt >= 2) ? handle_mem[handle_cnt-2] : '0;
        view.depth_now    = DEPTH_W'(handle_cnt);
        return view;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            handle_cnt = 0;
            view_queue.delete();
        end else begin
            // results first, so a word taken on this edge is never matched with itself
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (view_queue.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing outstanding, top %h",
                                              i_res_mon.top_value));
                end else begin
                    want_view = view_queue.pop_front();
                    check_field("top_value", i_res_mon.top_value, want_view.top_value);
                    check_field("second_value", i_res_mon.second_value,
                                want_view.second_value);
                    check_field("depth_now", VALUE_W'(i_res_mon.depth_now),
                                VALUE_W'(want_view.depth_now));
                    check_field("status", VALUE_W'(i_res_mon.status),
                                VALUE_W'(want_view.status));
                end
            end
            if (i_op_mon.valid && i_op_mon.ready)
                view_queue.push_back(apply_stack_op(i_op_mon.opcode, i_op_mon.value,
                                                    i_op_mon.count));
        end
        o_pending    <= view_queue.size();
        o_fail_count <= mismatch_total;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import ose_pkg::*;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_mix;

    localparam int STACK_ENTRIES = 64;
    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 4'd15;
    localparam int ITEM_TARGET = 1200;
    localparam int QUIET_FROM  = 1050;
    localparam int HOLD_AT     = 300;
    localparam int DRAIN_AT    = 650;
    localparam int LONG_HOLD   = 60;
    localparam int TAIL_CYCLES = 12;
    localparam int TIMEOUT_NS  = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   word_total;
    bit   quiet;
    bit   hold_off_req;
    int   burst_left;

    ose_in_if  op_ch ();
    ose_out_if res_ch ();

    operand_stack_engine #(
        .STACK_DEPTH  (STACK_ENTRIES),
        .HANDLE_WIDTH (VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    ose_check #(
        .STACK_DEPTH (STACK_ENTRIES)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_mon     (op_ch),
        .i_res_mon    (res_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;

    always #2 i_clk = ~i_clk;

    function automatic logic [OPCODE_W-1:0] any_opcode();
        if ($urandom_range(0, 11) == 0)
            return OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        return OPCODE_W'($urandom_range(OP_READ, OP_DROP_N_UNDER));
    endfunction

    function automatic logic [VALUE_W-1:0] random_handle();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly small counts, some up to just past the stack size, a few over the whole field
    function automatic logic [COUNT_W-1:0] random_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return COUNT_W'($urandom_range(0, 3));
        if (r < 9)
            return COUNT_W'($urandom_range(0, STACK_ENTRIES + 2));
        return COUNT_W'($urandom);
    endfunction

    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v,
                             input logic [COUNT_W-1:0] n);
        op_ch.valid  <= 1'b1;
        op_ch.opcode <= op;
        op_ch.value  <= v;
        op_ch.count  <= n;
        do @(posedge i_clk); while (!op_ch.ready);
        word_total++;
        if (!quiet && burst_left == 0 && $urandom_range(0, 5) == 0) begin
            op_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_random(input t_mix mix);
        int                  r;
        logic [OPCODE_W-1:0] op;
        r  = $urandom_range(0, 9);
        op = any_opcode();
        if (mix == MIX_GROW) begin
            if (r < 4)       op = OP_PUSH;
            else if (r == 4) op = OP_PUSH_UNDER;
            else if (r == 5) op = OP_DUP;
            else if (r == 6) op = OP_DUP_SECOND;
        end else if (mix == MIX_SHRINK) begin
            if (r < 3)       op = OP_POP;
            else if (r == 3) op = OP_POP_N;
            else if (r == 4) op = OP_DROP_SECOND;
            else if (r == 5) op = OP_DROP_N_UNDER;
        end
        send_word(op, random_handle(), random_count());
    endtask

    // sender stands still until every word it sent has come back
    task automatic wait_drained();
        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        t_mix mix;
        int   r;
        bit   hold_done;
        bit   drain_done;
        op_ch.valid  <= 1'b0;
        op_ch.opcode <= OP_READ;
        op_ch.value  <= '0;
        op_ch.count  <= '0;
        i_rst_n      <= 1'b0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        burst_left   = 0;
        word_total   = 0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // from an empty stack: reads, shortfalls, zero counts, every operation and spare opcodes
        send_word(OP_READ, 32'h0000_0000, 7'd0);
        send_word(OP_POP, 32'h0000_0000, 7'd0);
        send_word(OP_PUSH_UNDER, 32'hdead_beef, 7'd0);
        send_word(OP_SWAP, 32'h0000_0000, 7'd0);
        send_word(OP_POP_N, 32'h0000_0000, 7'd0);
        send_word(OP_DROP_N_UNDER, 32'h0000_0000, 7'd0);
        send_word(OP_PUSH, 32'hffff_ffff, 7'd0);
        send_word(OP_DUP_SECOND, 32'h0000_0000, 7'd0);
        send_word(OP_PUSH, 32'h0000_0000, 7'd0);
        send_word(OP_ROT, 32'h0000_0000, 7'd0);
        send_word(OP_PUSH_UNDER, 32'h8000_0001, 7'd0);
        send_word(OP_PUSH, 32'h1234_5678, 7'd0);
        send_word(OP_DUP, 32'h0000_0000, 7'd0);
        send_word(OP_DUP_SECOND, 32'h0000_0000, 7'd0);
        send_word(OP_SWAP, 32'h0000_0000, 7'd0);
        send_word(OP_ROT, 32'h0000_0000, 7'd0);
        send_word(OP_DROP_SECOND, 32'h0000_0000, 7'd0);
        send_word(OP_DROP_N_UNDER, 32'h0000_0000, 7'd2);
        send_word(OP_POP_N, 32'h0000_0000, 7'd127);
        send_word(OP_DROP_N_UNDER, 32'h0000_0000, 7'd64);
        send_word(OP_SPARE_FIRST, 32'h5a5a_a5a5, 7'd1);
        send_word(OP_SPARE_LAST, 32'ha5a5_5a5a, 7'd126);
        send_word(OP_POP_N, 32'h0000_0000, 7'd1);
        send_word(OP_POP, 32'h0000_0000, 7'd0);
        send_word(OP_READ, 32'h0000_0000, 7'd0);

        while (word_total < ITEM_TARGET) begin
            if (word_total >= QUIET_FROM)
                quiet = 1'b1;
            if (!hold_done && word_total >= HOLD_AT) begin
                // receiver holds off while words keep coming back to back
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                burst_left   = 40;
            end
            if (!drain_done && word_total >= DRAIN_AT) begin
                drain_done = 1'b1;
                wait_drained();
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                wait_drained();
            end

            r = $urandom_range(0, 7);
            if (r == 0)     mix = MIX_FILL;
            else if (r < 3) mix = MIX_GROW;
            else if (r < 5) mix = MIX_SHRINK;
            else            mix = MIX_ANY;

            if (mix == MIX_FILL) begin
                // enough pushes to fill from any depth, then growth and a rot on a full stack, then a deep drop
                repeat (STACK_ENTRIES + 2) send_word(OP_PUSH, random_handle(), random_count());
                send_word(OP_PUSH_UNDER, random_handle(), random_count());
                send_word(OP_DUP, random_handle(), random_count());
                send_word(OP_DUP_SECOND, random_handle(), random_count());
                send_word(OP_ROT, random_handle(), random_count());
                case ($urandom_range(0, 2))
                    0: send_word(OP_POP_N, random_handle(), COUNT_W'(STACK_ENTRIES));
                    1: send_word(OP_DROP_N_UNDER, random_handle(),
                                 COUNT_W'(STACK_ENTRIES - 1));
                    default: send_word(OP_DROP_N_UNDER, random_handle(),
                                       COUNT_W'(STACK_ENTRIES));
                endcase
            end else begin
                repeat ($urandom_range(5, 50)) send_random(mix);
            end
        end

        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : result_taker
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
